// File: hw/rtl/rssf_pkg.sv
// Shared types, constants and helper functions for the radix seven-segment formatter.
package rssf_pkg;

    // Active-low code with every segment off
    localparam logic [7:0] SEG_BLANK = 8'hff;

    // Byte address of the radix mode register
    localparam logic [1:0] REG_RADIX_ADDR = 2'd0;

    // Digit breakup selected by the radix register
    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_OCT = 2'd2,
        RADIX_BIN = 2'd3
    } radix_t;

    // Pipeline stage load enables
    typedef struct packed {
        logic en2;
        logic en3;
    } stage_en_t;

    // Five display positions, position 0 in the low byte
    typedef struct packed {
        logic [7:0] pos4;
        logic [7:0] pos3;
        logic [7:0] pos2;
        logic [7:0] pos1;
        logic [7:0] pos0;
    } seg_word_t;

    // Hex digit to active-low segment code
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'h0: code = 8'hc0;
            4'h1: code = 8'hf9;
            4'h2: code = 8'ha4;
            4'h3: code = 8'hb0;
            4'h4: code = 8'h99;
            4'h5: code = 8'h92;
            4'h6: code = 8'h82;
            4'h7: code = 8'hf8;
            4'h8: code = 8'h80;
            4'h9: code = 8'h98;
            4'ha: code = 8'h88;
            4'hb: code = 8'h83;
            4'hc: code = 8'hc6;
            4'hd: code = 8'ha1;
            4'he: code = 8'h86;
            default: code = 8'h8e;
        endcase
        return code;
    endfunction

    // Split a value below 100 into tens (high nibble) and ones (low nibble)
    function automatic logic [7:0] split99(input logic [6:0] x);
        logic [17:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 18'(x) * 18'd205;
        tens = prod[14:11];
        ones = x - 7'(7'(tens) * 7'd10);
        return {tens, ones[3:0]};
    endfunction

endpackage

// File: hw/rtl/radix_seven_segment_formatter.sv
// Top level of the radix seven-segment formatter: handshakes, config and pipeline control.
//
// Usage:
//   Input requests arrive on s_tvalid/s_tready/s_tdata, one 16-bit value each.
//   Each request yields one result on m_tvalid/m_tready/m_tdata: five
//   active-low segment bytes for a four-digit display with a colon slot at
//   position 2, which is always blank.
//   The radix register (APB byte address 0) picks decimal, hex, octal or
//   binary digits; write it only while no request is in flight.
// Timing:
//   Requests pass from acceptance to m_tvalid through a four-register
//   pipeline (input, modulo 10000, hundreds split, result).
//   Throughput is one request per cycle while m_tready is high; each stage
//   loads whenever it is empty or the stage after it moves, so bubbles collapse.
// Reset:
//   rst_n clears all valid flags and sets the radix to decimal.
// Stall:
//   When m_tready is low the result holds, the stages behind it fill up, and
//   s_tready drops once all four stages hold a request.
module radix_seven_segment_formatter
    import rssf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] value
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [7:0] seg_pos0, [15:8] seg_pos1, [23:16] seg_pos2,
                                   // [31:24] seg_pos3, [39:32] seg_pos4
);

    radix_t      radix_reg;
    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    logic        vo_reg;
    logic [15:0] value1_reg;
    seg_word_t   out_reg;
    seg_word_t   out_next;
    logic        en1;
    logic        en2;
    logic        en3;
    logic        en_o;
    stage_en_t   stage_en;
    logic [6:0]  hund3;
    logic [6:0]  rem3_lo;
    logic [15:0] raw3;

    // Load enables: a stage loads when empty or when its successor moves
    always_comb
    begin
        en_o = !vo_reg || m_tready;
        en3  = !v3_reg || en_o;
        en2  = !v2_reg || en3;
        en1  = !v1_reg || en2;
        stage_en.en2 = en2;
        stage_en.en3 = en3;
    end

    assign s_tready = en1;

    // Radix register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_DEC;
        end
        else if (psel && penable && pwrite && paddr == REG_RADIX_ADDR)
        begin
            radix_reg <= radix_t'(pwdata[1:0]);
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_RADIX_ADDR) ? {30'd0, radix_reg} : 32'd0;

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en1)  v1_reg <= s_tvalid;
            if (en2)  v2_reg <= v1_reg;
            if (en3)  v3_reg <= v2_reg;
            if (en_o) vo_reg <= v3_reg;
        end
    end

    // Input and result payload registers
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            value1_reg <= s_tdata;
        end
        if (en_o)
        begin
            out_reg <= out_next;
        end
    end

    rssf_dec_split u_dec_split (
        .clk      (clk),
        .stage_en (stage_en),
        .value1   (value1_reg),
        .hund3    (hund3),
        .rem3_lo  (rem3_lo),
        .raw3     (raw3)
    );

    rssf_seg_encode u_seg_encode (
        .radix    (radix_reg),
        .hund3    (hund3),
        .rem3_lo  (rem3_lo),
        .raw3     (raw3),
        .segs     (out_next)
    );

    assign m_tvalid = vo_reg;
    assign m_tdata  = out_reg;

    // Colon slot is always blank on a valid result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_reg.pos2 == SEG_BLANK)
        else $error("colon slot not blank");

    // Lowest position always shows a digit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_reg.pos0 != SEG_BLANK)
        else $error("position 0 blanked");

    // A shown top digit implies the digits below it are shown too
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.pos4 != SEG_BLANK) |->
            (out_reg.pos3 != SEG_BLANK && out_reg.pos1 != SEG_BLANK))
        else $error("blanking gap below a shown digit");

    // An empty result register never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !vo_reg |-> s_tready)
        else $error("input stalled with empty result register");

    // A request in the last stage enters the result register when that register loads
    assert property (@(posedge clk) disable iff (!rst_n)
        (en_o && v3_reg) |=> vo_reg)
        else $error("result lost between stages");

endmodule

// File: hw/rtl/rssf_dec_split.sv
// Decimal front end: modulo 10000 and hundreds split over two register stages.
module rssf_dec_split
    import rssf_pkg::*;
(
    input  logic        clk,
    input  stage_en_t   stage_en,
    input  logic [15:0] value1,
    output logic [6:0]  hund3,
    output logic [6:0]  rem3_lo,
    output logic [15:0] raw3
);

    logic [13:0] mod_reg;
    logic [13:0] mod_next;
    logic [15:0] raw2_reg;
    logic [6:0]  hund_reg;
    logic [6:0]  hund_next;
    logic [6:0]  rem_lo_reg;
    logic [15:0] raw3_reg;
    logic [2:0]  tenk;
    logic [15:0] tenk_val;
    logic [26:0] prod;

    // Count whole ten-thousands with parallel compares
    always_comb
    begin
        tenk = 3'd0;
        if (value1 >= 16'd10000) tenk = 3'd1;
        if (value1 >= 16'd20000) tenk = 3'd2;
        if (value1 >= 16'd30000) tenk = 3'd3;
        if (value1 >= 16'd40000) tenk = 3'd4;
        if (value1 >= 16'd50000) tenk = 3'd5;
        if (value1 >= 16'd60000) tenk = 3'd6;
        case (tenk)
            3'd1:    tenk_val = 16'd10000;
            3'd2:    tenk_val = 16'd20000;
            3'd3:    tenk_val = 16'd30000;
            3'd4:    tenk_val = 16'd40000;
            3'd5:    tenk_val = 16'd50000;
            3'd6:    tenk_val = 16'd60000;
            default: tenk_val = 16'd0;
        endcase
        mod_next = 14'(value1 - tenk_val);
    end

    // Hundreds by reciprocal multiply, exact for values below 10000
    always_comb
    begin
        prod      = 27'(mod_reg) * 27'd5243;
        hund_next = prod[25:19];
    end

    // Advance the payload registers
    always_ff @(posedge clk)
    begin
        if (stage_en.en2)
        begin
            mod_reg  <= mod_next;
            raw2_reg <= value1;
        end
        if (stage_en.en3)
        begin
            hund_reg   <= hund_next;
            rem_lo_reg <= mod_reg[6:0];
            raw3_reg   <= raw2_reg;
        end
    end

    assign hund3   = hund_reg;
    assign rem3_lo = rem_lo_reg;
    assign raw3    = raw3_reg;

endmodule

// File: hw/rtl/rssf_seg_encode.sv
// Digit selection by radix, segment lookup and leading-zero blanking.
module rssf_seg_encode
    import rssf_pkg::*;
(
    input  radix_t      radix,
    input  logic [6:0]  hund3,
    input  logic [6:0]  rem3_lo,
    input  logic [15:0] raw3,
    output seg_word_t   segs
);

    logic [13:0] hund_x100;
    logic [6:0]  below_hund;
    logic [7:0]  hi_pair;
    logic [7:0]  lo_pair;
    logic [3:0]  dg0;
    logic [3:0]  dg1;
    logic [3:0]  dg2;
    logic [3:0]  dg3;
    logic        blank3;
    logic        blank2;
    logic        blank1;

    // Finish the decimal split: value below 100 and two digit pairs
    always_comb
    begin
        hund_x100  = 14'(hund3) * 14'd100;
        below_hund = rem3_lo - hund_x100[6:0];
        hi_pair    = split99(hund3);
        lo_pair    = split99(below_hund);
    end

    // Pick the four digits for the current radix
    always_comb
    begin
        case (radix)
            RADIX_DEC:
            begin
                dg0 = lo_pair[3:0];
                dg1 = lo_pair[7:4];
                dg2 = hi_pair[3:0];
                dg3 = hi_pair[7:4];
            end
            RADIX_HEX:
            begin
                dg0 = raw3[3:0];
                dg1 = raw3[7:4];
                dg2 = raw3[11:8];
                dg3 = raw3[15:12];
            end
            RADIX_OCT:
            begin
                dg0 = {1'b0, raw3[2:0]};
                dg1 = {1'b0, raw3[5:3]};
                dg2 = {1'b0, raw3[8:6]};
                dg3 = {1'b0, raw3[11:9]};
            end
            default:
            begin
                dg0 = {3'b000, raw3[0]};
                dg1 = {3'b000, raw3[1]};
                dg2 = {3'b000, raw3[2]};
                dg3 = {3'b000, raw3[3]};
            end
        endcase
    end

    // Blank zeros from the top down; the lowest digit always shows
    always_comb
    begin
        blank3    = (dg3 == 4'd0);
        blank2    = blank3 && (dg2 == 4'd0);
        blank1    = blank2 && (dg1 == 4'd0);
        segs.pos0 = seg_code(dg0);
        segs.pos1 = blank1 ? SEG_BLANK : seg_code(dg1);
        segs.pos2 = SEG_BLANK;
        segs.pos3 = blank2 ? SEG_BLANK : seg_code(dg2);
        segs.pos4 = blank3 ? SEG_BLANK : seg_code(dg3);
    end

endmodule
